// ===== sv/pgst_pkg.sv =====
// Shared constants for the pair group soft threshold block.
package pgst_pkg;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int THR_W            = 16;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;
    localparam logic REG_THRESHOLD  = 1'b0;
endpackage

// ===== sv/pgst_sqrt_step.sv =====
// One registered digit step of the pipelined floor square root.
module pgst_sqrt_step #(
    parameter int SAMPLE_WIDTH = pgst_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [SAMPLE_WIDTH:0]     i_rem,
    input  logic [SAMPLE_WIDTH-1:0]   i_root,
    input  logic [2*SAMPLE_WIDTH-1:0] i_sq,
    output logic [SAMPLE_WIDTH:0]     o_rem,
    output logic [SAMPLE_WIDTH-1:0]   o_root,
    output logic [2*SAMPLE_WIDTH-1:0] o_sq
);
    localparam int SW = SAMPLE_WIDTH;

    logic [SW+2:0] w_cur;
    logic [SW+2:0] w_trial;
    logic [SW:0]   n_rem;
    logic [SW-1:0] n_root;
    logic [SW:0]   r_rem;
    logic [SW-1:0] r_root;
    logic [2*SW-1:0] r_sq;

    always_comb begin
        w_cur   = {i_rem, i_sq[2*SW-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        if (w_cur >= w_trial) begin
            n_rem  = (SW+1)'(w_cur - w_trial);
            n_root = {i_root[SW-2:0], 1'b1};
        end else begin
            n_rem  = w_cur[SW:0];
            n_root = {i_root[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_sq   <= {i_sq[2*SW-3:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_sq   = r_sq;
endmodule

// ===== sv/pgst_div_step.sv =====
// One registered bit step of the pipelined restoring divider.
module pgst_div_step #(
    parameter int SAMPLE_WIDTH = pgst_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [SAMPLE_WIDTH-1:0] i_rem,
    input  logic [SAMPLE_WIDTH-1:0] i_lo,
    input  logic [SAMPLE_WIDTH-1:0] i_div,
    output logic [SAMPLE_WIDTH-1:0] o_rem,
    output logic [SAMPLE_WIDTH-1:0] o_lo
);
    localparam int SW = SAMPLE_WIDTH;

    logic [SW:0]   w_t;
    logic          w_ge;
    logic [SW-1:0] n_rem;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_lo;

    always_comb begin
        w_t  = {i_rem, i_lo[SW-1]};
        w_ge = (w_t >= {1'b0, i_div});
        if (w_ge) begin
            n_rem = SW'(w_t - {1'b0, i_div});
        end else begin
            n_rem = w_t[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_lo  <= {i_lo[SW-2:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_lo  = r_lo;
endmodule

// ===== sv/pair_group_soft_threshold.sv =====
// Top level: pipelined l2 group soft threshold of a sample pair.
// Throughput: one pair per cycle while the output is not stalled;
// the square root and divider stages take one bit each.
// Stages advance on their own, so bubbles close up while the output beat waits.
// Reset (synchronous, active low) clears all valid bits and sets the threshold to 0.
module pair_group_soft_threshold #(
    parameter int SAMPLE_WIDTH = pgst_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pgst_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [pgst_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [pgst_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // first_component, second_component
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // first_shrunk, second_shrunk
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // zeroed
    output logic                                   m_axis_tuser
);
    import pgst_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = ((2*SW+7)/8)*8;
    localparam int P  = 2*SW+5;
    localparam int SQ0 = 2;
    localparam int SC  = SW+2;
    localparam int SD  = SW+3;
    localparam int DV0 = SW+4;
    localparam int SE  = 2*SW+4;
    localparam int CW  = ((SW > THR_W) ? SW : THR_W) + 1;

    logic [THR_W-1:0] r_threshold;
    logic [P-1:0]     r_v;
    logic [P:0]       w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
            r_threshold <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_DATA_W'(r_threshold) : '0;

    // elastic advance chain
    always_comb begin
        w_en[P] = m_axis_tready;
        for (int k = P-1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < P; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= (k == 0) ? s_axis_tvalid : r_v[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];

    // stage 0: magnitudes and signs
    logic [SW-1:0] w_x1, w_x2;
    logic [SW-1:0] r_m1_a, r_m2_a;
    logic [1:0]    r_n_a;

    assign w_x1 = s_axis_tdata[SW-1:0];
    assign w_x2 = s_axis_tdata[2*SW-1:SW];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_m1_a <= w_x1[SW-1] ? SW'(-w_x1) : w_x1;
            r_m2_a <= w_x2[SW-1] ? SW'(-w_x2) : w_x2;
            r_n_a  <= {w_x2[SW-1], w_x1[SW-1]};
        end
    end

    // stage 1: sum of squares
    logic [2*SW-1:0] r_s_b;
    logic [SW-1:0]   r_m1_b, r_m2_b;
    logic [1:0]      r_n_b;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s_b  <= (2*SW)'(r_m1_a * r_m1_a) + (2*SW)'(r_m2_a * r_m2_a);
            r_m1_b <= r_m1_a;
            r_m2_b <= r_m2_a;
            r_n_b  <= r_n_a;
        end
    end

    // square root stages
    logic [SW:0]     w_qrem  [SW+1];
    logic [SW-1:0]   w_qroot [SW+1];
    logic [2*SW-1:0] w_qsq   [SW+1];
    logic [SW-1:0]   r_qm1 [SW];
    logic [SW-1:0]   r_qm2 [SW];
    logic [1:0]      r_qn  [SW];

    assign w_qrem[0]  = '0;
    assign w_qroot[0] = '0;
    assign w_qsq[0]   = r_s_b;

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        pgst_sqrt_step #(.SAMPLE_WIDTH(SW)) u_step (
            .i_clk  (i_clk),
            .i_en   (w_en[SQ0+k]),
            .i_rem  (w_qrem[k]),
            .i_root (w_qroot[k]),
            .i_sq   (w_qsq[k]),
            .o_rem  (w_qrem[k+1]),
            .o_root (w_qroot[k+1]),
            .o_sq   (w_qsq[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en[SQ0+k]) begin
                r_qm1[k] <= (k == 0) ? r_m1_b : r_qm1[(k == 0) ? 0 : k-1];
                r_qm2[k] <= (k == 0) ? r_m2_b : r_qm2[(k == 0) ? 0 : k-1];
                r_qn[k]  <= (k == 0) ? r_n_b  : r_qn[(k == 0) ? 0 : k-1];
            end
        end
    end

    // stage C: compare against threshold
    logic [CW-1:0] w_b_ext, w_tau_ext;
    logic [SW-1:0] r_b_c, r_d_c, r_m1_c, r_m2_c;
    logic          r_z_c;
    logic [1:0]    r_n_c;

    assign w_b_ext   = CW'(w_qroot[SW]);
    assign w_tau_ext = CW'(r_threshold);

    always_ff @(posedge i_clk) begin
        if (w_en[SC]) begin
            r_b_c  <= w_qroot[SW];
            r_d_c  <= SW'(w_b_ext - w_tau_ext);
            r_z_c  <= (w_b_ext <= w_tau_ext);
            r_m1_c <= r_qm1[SW-1];
            r_m2_c <= r_qm2[SW-1];
            r_n_c  <= r_qn[SW-1];
        end
    end

    // stage D: numerators
    logic [2*SW-1:0] r_num1_d, r_num2_d;
    logic [SW-1:0]   r_b_d;
    logic            r_z_d;
    logic [1:0]      r_n_d;

    always_ff @(posedge i_clk) begin
        if (w_en[SD]) begin
            r_num1_d <= r_z_c ? '0 : (2*SW)'(r_m1_c * r_d_c);
            r_num2_d <= r_z_c ? '0 : (2*SW)'(r_m2_c * r_d_c);
            r_b_d    <= r_b_c;
            r_z_d    <= r_z_c;
            r_n_d    <= r_n_c;
        end
    end

    // divider stages, two lanes sharing the divisor
    logic [SW-1:0] w_r1 [SW+1];
    logic [SW-1:0] w_l1 [SW+1];
    logic [SW-1:0] w_r2 [SW+1];
    logic [SW-1:0] w_l2 [SW+1];
    logic [SW-1:0] w_dv [SW+1];
    logic [SW-1:0] r_dv [SW];
    logic          r_dz [SW];
    logic [1:0]    r_dn [SW];

    assign w_r1[0] = r_num1_d[2*SW-1:SW];
    assign w_l1[0] = r_num1_d[SW-1:0];
    assign w_r2[0] = r_num2_d[2*SW-1:SW];
    assign w_l2[0] = r_num2_d[SW-1:0];
    assign w_dv[0] = r_b_d;

    for (genvar k = 0; k < SW; k++) begin : g_div
        pgst_div_step #(.SAMPLE_WIDTH(SW)) u_lane1 (
            .i_clk (i_clk),
            .i_en  (w_en[DV0+k]),
            .i_rem (w_r1[k]),
            .i_lo  (w_l1[k]),
            .i_div (w_dv[k]),
            .o_rem (w_r1[k+1]),
            .o_lo  (w_l1[k+1])
        );
        pgst_div_step #(.SAMPLE_WIDTH(SW)) u_lane2 (
            .i_clk (i_clk),
            .i_en  (w_en[DV0+k]),
            .i_rem (w_r2[k]),
            .i_lo  (w_l2[k]),
            .i_div (w_dv[k]),
            .o_rem (w_r2[k+1]),
            .o_lo  (w_l2[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en[DV0+k]) begin
                r_dv[k] <= w_dv[k];
                r_dz[k] <= (k == 0) ? r_z_d : r_dz[(k == 0) ? 0 : k-1];
                r_dn[k] <= (k == 0) ? r_n_d : r_dn[(k == 0) ? 0 : k-1];
            end
        end
        assign w_dv[k+1] = r_dv[k];
    end

    // stage E: sign restore and output beat
    logic [SW-1:0] r_o1, r_o2;
    logic          r_oz;
    logic [SW-1:0] w_q1, w_q2;
    logic          w_fz;
    logic [1:0]    w_fn;

    assign w_q1 = w_l1[SW];
    assign w_q2 = w_l2[SW];
    assign w_fz = r_dz[SW-1];
    assign w_fn = r_dn[SW-1];

    always_ff @(posedge i_clk) begin
        if (w_en[SE]) begin
            r_o1 <= w_fz ? '0 : (w_fn[0] ? SW'(-w_q1) : w_q1);
            r_o2 <= w_fz ? '0 : (w_fn[1] ? SW'(-w_q2) : w_q2);
            r_oz <= w_fz;
        end
    end

    assign m_axis_tvalid = r_v[SE];
    assign m_axis_tdata  = DW'({r_o2, r_o1});
    assign m_axis_tuser  = r_oz;
endmodule

// ===== sv/pgst_checker.sv =====
// Port-level checker for the pair group soft threshold block, with its bind.
module pgst_checker #(
    parameter int SAMPLE_WIDTH = pgst_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic                                m_axis_tuser
);
    localparam int SW = SAMPLE_WIDTH;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid after reset");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[2*SW-1:0] == '0))
        else $error("zeroed beat carries nonzero samples");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output beat changed");

    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output side is empty");
endmodule

bind pair_group_soft_threshold pgst_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pgst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
